// ----- design/sttr_pkg.sv -----
// ----------------------------------------------------------------------------
// sttr_pkg: shared types and constants of the scope trace span renderer
// Configuration register codes, span row type and the row mapping function.
// ----------------------------------------------------------------------------
package sttr_pkg;

	// channels that own configuration registers
	localparam int NUM_CFG_CH = 2;

	localparam int GAIN_W   = 20;
	localparam int OFFSET_W = 8;
	localparam int COLOR_W  = 16;
	localparam int SAMPLE_W = 12;
	localparam int VALUE_W  = 8;
	localparam int ROW_W    = 8;
	localparam int COLUMN_W = 9;
	localparam int PROD_W   = SAMPLE_W + GAIN_W;
	localparam int FRAC_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [COLOR_W-1:0] ERASE_COLOR = 16'h0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_CH0   = 3'd0,
		CFG_GAIN_CH1   = 3'd1,
		CFG_OFFSET_CH0 = 3'd2,
		CFG_OFFSET_CH1 = 3'd3,
		CFG_COLOR_CH0  = 3'd4,
		CFG_COLOR_CH1  = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		logic [ROW_W-1:0] top;
		logic [ROW_W-1:0] bottom;
	} span_rows_t;

	// order the two ends, lift an all-zero span to one row, map to screen rows
	function automatic span_rows_t span_rows(input logic [VALUE_W-1:0] a,
		input logic [VALUE_W-1:0] b, input logic [ROW_W-1:0] rows);
		logic [VALUE_W-1:0] hi;
		logic [VALUE_W-1:0] lo;
		span_rows_t r;
		hi = (a > b) ? a : b;
		lo = (a > b) ? b : a;
		if ((hi | lo) == '0) begin
			hi = VALUE_W'(1);
		end
		r.top    = rows - hi;
		r.bottom = rows - lo;
		return r;
	endfunction

endpackage

// ----- design/scope_trace_span_renderer.sv -----
// ----------------------------------------------------------------------------
// scope_trace_span_renderer: oscilloscope trace erase/draw span generator
// Scales ADC samples per channel and emits erase and draw spans per column.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, channel, sample): one ADC sample per
//   request, meant for the next display column of that channel. A request is
//   taken on a rising edge with in_valid high and in_stall low. A request for
//   a channel at or above CHANNELS is taken and dropped without any result.
//   Output channel (out_valid / out_stall): each sample gives two requests in
//   the same column, first the black erase of the old segment (last low),
//   then the draw of the new segment in the channel color (last high).
//   Order: the erase span shows once the sample has passed stage 1 and
//   reached stage 2; the draw span follows it once the erase span is taken.
//   The two spans of a sample share the single output channel, and stage 1
//   can take the next sample while they drain; the trace store is read once
//   at accept and written once when the sample moves into the output register.
//   Config port (cfg_valid / cfg_ready, cfg_index, cfg_data): always ready;
//   write only while the block holds no work.
//   Reset: registers return to their defaults, columns and per-channel
//   history clear, and a per-channel frame-complete flag marks the trace
//   store as all zero until every column of that channel has been written,
//   so no clearing pass is needed. While out_stall is high the output span
//   holds, one sample waits in the stage behind it, and then in_stall rises.
// ----------------------------------------------------------------------------
module scope_trace_span_renderer #(
	parameter int TRACE_WIDTH = 320,
	parameter int SCREEN_ROWS = 240,
	parameter int CHANNELS    = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample requests
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                channel,
	input  logic [sttr_pkg::SAMPLE_W-1:0]       sample,
	// span requests
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sttr_pkg::COLUMN_W-1:0]       column,
	output logic [sttr_pkg::ROW_W-1:0]          row_top,
	output logic [sttr_pkg::ROW_W-1:0]          row_bottom,
	output logic [sttr_pkg::COLOR_W-1:0]        pixel_color,
	output logic                                is_draw,
	output logic                                last,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sttr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sttr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import sttr_pkg::*;

	// channels that can actually carry samples (channel input is one bit)
	localparam int USED_CH   = (CHANNELS < NUM_CFG_CH) ? CHANNELS : NUM_CFG_CH;
	localparam int DEPTH     = USED_CH * TRACE_WIDTH;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW        = $clog2(TRACE_WIDTH);
	localparam int VALUE_MAX = ((SCREEN_ROWS - 1) < 255) ? (SCREEN_ROWS - 1) : 255;
	localparam int SCALED_W  = PROD_W - FRAC_W + 1;
	localparam logic CH1_OK  = (CHANNELS > 1);
	localparam logic [ROW_W-1:0]    ROWS_LOW  = ROW_W'(SCREEN_ROWS);
	localparam logic [CW-1:0]       COL_LAST  = CW'(TRACE_WIDTH - 1);
	localparam logic [SCALED_W-1:0] VMAX_WIDE = SCALED_W'(VALUE_MAX);
	localparam logic [AW-1:0]       CH1_BASE  = AW'(TRACE_WIDTH);

	// configuration registers
	logic [GAIN_W-1:0]   gain_q   [NUM_CFG_CH];
	logic [OFFSET_W-1:0] offset_q [NUM_CFG_CH];
	logic [COLOR_W-1:0]  color_q  [NUM_CFG_CH];

	// per-channel control state
	logic [CW-1:0]      col_q      [NUM_CFG_CH];
	logic               wrapped_q  [NUM_CFG_CH];
	logic [VALUE_W-1:0] last_old_q [NUM_CFG_CH];
	logic [VALUE_W-1:0] last_new_q [NUM_CFG_CH];

	// stage 1: product and trace store read in flight
	logic              s1_full_q;
	logic              ch_s1;
	logic [CW-1:0]     col_s1;
	logic              oldok_s1;
	logic [PROD_W-1:0] prod_s1;

	// stage 2: both spans of one sample, emitted erase first
	logic                s2_full_q;
	logic                phase_q;
	logic [COLUMN_W-1:0] col_s2;
	span_rows_t          erase_s2;
	span_rows_t          draw_s2;
	logic [COLOR_W-1:0]  color_s2;

	logic               accept;
	logic               take;
	logic               s1_move;
	logic               out_take;
	logic [CW-1:0]      col_in;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic [VALUE_W-1:0] ram_rdata;
	logic [SCALED_W-1:0] scaled;
	logic [VALUE_W-1:0] new_val;
	logic [VALUE_W-1:0] old_val;
	logic [VALUE_W-1:0] prev_old;
	logic [VALUE_W-1:0] prev_new;
	logic               first_col;
	span_rows_t         erase_rows;
	span_rows_t         draw_rows;
	logic [31:0]        col_wide;

	// ------------------------------------------------------------------
	// handshakes
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign out_valid = s2_full_q;
	assign out_take  = s2_full_q && !out_stall;
	// stage 1 moves on when stage 2 is empty or about to drain its draw span
	assign s1_move   = s1_full_q && (!s2_full_q || (phase_q && !out_stall));
	assign in_stall  = s1_full_q && !s1_move;
	assign accept    = in_valid && !in_stall;
	// drop samples of channels that are not built
	assign take      = accept && (!channel || CH1_OK);

	// ------------------------------------------------------------------
	// trace store: read at accept, write back as the sample leaves stage 1.
	// A column is revisited only after TRACE_WIDTH (at least two) samples of
	// its channel, so the write always lands before the next read of it.
	// ------------------------------------------------------------------
	assign col_in = col_q[channel];
	assign raddr  = channel ? (CH1_BASE + AW'(col_in)) : AW'(col_in);
	assign waddr  = ch_s1 ? (CH1_BASE + AW'(col_s1)) : AW'(col_s1);

	sttr_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_trace_ram (
		.clk   (clk),
		.we    (s1_move),
		.waddr (waddr),
		.wdata (new_val),
		.re    (take),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// stage 1 arithmetic: scale, offset, clamp, pick span ends
	// ------------------------------------------------------------------
	always_comb begin
		scaled = {1'b0, prod_s1[PROD_W-1:FRAC_W]} + SCALED_W'(offset_q[ch_s1]);
		new_val = (scaled > VMAX_WIDE) ? VALUE_W'(VALUE_MAX) : scaled[VALUE_W-1:0];
		// entries not yet written this first frame read as zero
		old_val = oldok_s1 ? ram_rdata : '0;
		first_col = (col_s1 == '0);
		prev_old = first_col ? old_val : last_old_q[ch_s1];
		prev_new = first_col ? new_val : last_new_q[ch_s1];
		erase_rows = span_rows(prev_old, old_val, ROWS_LOW);
		draw_rows  = span_rows(prev_new, new_val, ROWS_LOW);
		col_wide   = 32'(col_s1);
	end

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q[0]   <= GAIN_W'(28494);
			gain_q[1]   <= GAIN_W'(28494);
			offset_q[0] <= OFFSET_W'(18);
			offset_q[1] <= OFFSET_W'(114);
			color_q[0]  <= 16'hFFE0;
			color_q[1]  <= 16'h07FF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GAIN_CH0:   gain_q[0]   <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_CH1:   gain_q[1]   <= cfg_data[GAIN_W-1:0];
				CFG_OFFSET_CH0: offset_q[0] <= cfg_data[OFFSET_W-1:0];
				CFG_OFFSET_CH1: offset_q[1] <= cfg_data[OFFSET_W-1:0];
				CFG_COLOR_CH0:  color_q[0]  <= cfg_data[COLOR_W-1:0];
				CFG_COLOR_CH1:  color_q[1]  <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// per-channel column counters and history
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG_CH; i++) begin
				col_q[i]      <= '0;
				wrapped_q[i]  <= 1'b0;
				last_old_q[i] <= '0;
				last_new_q[i] <= '0;
			end
		end else begin
			// advance the column at accept so the next read sees it
			if (take) begin
				if (col_in == COL_LAST) begin
					col_q[channel]     <= '0;
					wrapped_q[channel] <= 1'b1;
				end else begin
					col_q[channel] <= col_in + CW'(1);
				end
			end
			if (s1_move) begin
				last_old_q[ch_s1] <= old_val;
				last_new_q[ch_s1] <= new_val;
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 1 and stage 2 control
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_full_q <= 1'b0;
			s2_full_q <= 1'b0;
			phase_q   <= 1'b0;
		end else begin
			if (take) begin
				s1_full_q <= 1'b1;
			end else if (s1_move) begin
				s1_full_q <= 1'b0;
			end
			if (s1_move) begin
				s2_full_q <= 1'b1;
				phase_q   <= 1'b0;
			end else if (out_take) begin
				if (phase_q) begin
					s2_full_q <= 1'b0;
					phase_q   <= 1'b0;
				end else begin
					phase_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			ch_s1    <= channel;
			col_s1   <= col_in;
			oldok_s1 <= wrapped_q[channel];
			prod_s1  <= PROD_W'(sample) * PROD_W'(gain_q[channel]);
		end
		if (s1_move) begin
			col_s2   <= col_wide[COLUMN_W-1:0];
			erase_s2 <= erase_rows;
			draw_s2  <= draw_rows;
			color_s2 <= color_q[ch_s1];
		end
	end

	// ------------------------------------------------------------------
	// output mux: erase span, then draw span
	// ------------------------------------------------------------------
	assign column      = col_s2;
	assign row_top     = phase_q ? draw_s2.top : erase_s2.top;
	assign row_bottom  = phase_q ? draw_s2.bottom : erase_s2.bottom;
	assign pixel_color = phase_q ? color_s2 : ERASE_COLOR;
	assign is_draw     = phase_q;
	assign last        = phase_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_full_q)
		else $error("input stalled with stage 1 empty");

	a_draw_follows_erase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> (out_valid && last))
		else $error("erase span not followed by draw span");

	a_pair_same_column: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> (column == $past(column)))
		else $error("draw span column differs from erase span");

	a_frame_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wrapped_q[0] |=> wrapped_q[0])
		else $error("frame-complete flag cleared without reset");

	a_stage2_fed_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> (out_valid && !last))
		else $error("stage 2 not loaded with a fresh erase span");

endmodule

// ----- design/sttr_ram.sv -----
// ----------------------------------------------------------------------------
// sttr_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with enable; read data registered.
// ----------------------------------------------------------------------------
module sttr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 640,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the scope trace span renderer
// Sends ADC sample requests through a queue-fed driver and predicts the erase
// and draw span of each one, from a private copy of the trace store, columns
// and registers. A monitor then checks every span request field by field.
// ----------------------------------------------------------------------------
module tb;
	import sttr_pkg::*;

	localparam int TRACE_COLS = 320;
	localparam int ROWS       = 240;
	localparam int TOP_VALUE  = ROWS - 1;
	localparam int NUM_CH     = 2;
	localparam int PHASE_SAMPLES = 110;
	// worst phase: 88% output stall, two spans per sample; allow many times that
	localparam int TIMEOUT_CYCLES = 300000;

	typedef struct {
		logic                ch;
		logic [SAMPLE_W-1:0] smp;
	} sample_req_t;

	typedef struct {
		logic [COLUMN_W-1:0] column;
		logic [ROW_W-1:0]    row_top;
		logic [ROW_W-1:0]    row_bottom;
		logic [COLOR_W-1:0]  pixel_color;
		logic                is_draw;
		logic                last;
	} span_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  channel = 1'b0;
	logic [SAMPLE_W-1:0]   sample = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [COLUMN_W-1:0]   column;
	logic [ROW_W-1:0]      row_top;
	logic [ROW_W-1:0]      row_bottom;
	logic [COLOR_W-1:0]    pixel_color;
	logic                  is_draw;
	logic                  last;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// pending sample requests and the spans they must produce, oldest first
	sample_req_t sample_queue[$];
	span_t       span_queue[$];

	// private copy of the renderer state and its registers
	logic [VALUE_W-1:0]  trace_mem [NUM_CH][TRACE_COLS];
	int                  col_next  [NUM_CH];
	logic [VALUE_W-1:0]  left_new_v[NUM_CH];
	logic [VALUE_W-1:0]  left_old_v[NUM_CH];
	logic [GAIN_W-1:0]   gain_reg  [NUM_CH];
	logic [OFFSET_W-1:0] offset_reg[NUM_CH];
	logic [COLOR_W-1:0]  color_reg [NUM_CH];

	int idle_pct  = 0;
	int stall_pct = 0;
	int err_cnt   = 0;
	bit req_taken   = 1'b0;
	bit cfg_written = 1'b0;

	scope_trace_span_renderer #(
		.TRACE_WIDTH(TRACE_COLS),
		.SCREEN_ROWS(ROWS),
		.CHANNELS(NUM_CH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.channel(channel),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.column(column),
		.row_top(row_top),
		.row_bottom(row_bottom),
		.pixel_color(pixel_color),
		.is_draw(is_draw),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Order the two ends, lift an all-zero span to one row, map values to rows.
	function automatic span_t make_span(input int col, input logic [VALUE_W-1:0] a,
		input logic [VALUE_W-1:0] b, input logic [COLOR_W-1:0] color, input logic draw);
		logic [VALUE_W-1:0] hi;
		logic [VALUE_W-1:0] lo;
		span_t s;
		hi = (a > b) ? a : b;
		lo = (a > b) ? b : a;
		if (hi == 0 && lo == 0) begin
			hi = VALUE_W'(1);
		end
		s.column      = COLUMN_W'(col);
		s.row_top     = ROW_W'(ROWS - int'(hi));
		s.row_bottom  = ROW_W'(ROWS - int'(lo));
		s.pixel_color = color;
		s.is_draw     = draw;
		s.last        = draw;
		return s;
	endfunction

	// Scale one accepted sample, queue its erase and draw spans, advance the column.
	task automatic render_sample(input logic ch, input logic [SAMPLE_W-1:0] smp);
		logic [31:0]        prod;
		logic [16:0]        scaled;
		logic [VALUE_W-1:0] new_v;
		logic [VALUE_W-1:0] old_v;
		logic [VALUE_W-1:0] from_old;
		logic [VALUE_W-1:0] from_new;
		int                 col;
		prod   = 32'(smp) * 32'(gain_reg[ch]);
		scaled = 17'(prod >> FRAC_W) + 17'(offset_reg[ch]);
		new_v  = (scaled > 17'(TOP_VALUE)) ? VALUE_W'(TOP_VALUE) : scaled[VALUE_W-1:0];
		col    = col_next[ch];
		old_v  = trace_mem[ch][col];
		// column zero has no left neighbor: both ends come from this column
		if (col == 0) begin
			from_old = old_v;
			from_new = new_v;
		end else begin
			from_old = left_old_v[ch];
			from_new = left_new_v[ch];
		end
		span_queue.push_back(make_span(col, from_old, old_v, ERASE_COLOR, 1'b0));
		span_queue.push_back(make_span(col, from_new, new_v, color_reg[ch], 1'b1));
		trace_mem[ch][col] = new_v;
		left_old_v[ch] = old_v;
		left_new_v[ch] = new_v;
		col_next[ch] = (col + 1 >= TRACE_COLS) ? 0 : col + 1;
	endtask

	// Sample handshakes at the rising edge: track accepted requests, check spans,
	// and mirror register writes.
	always @(posedge clk) begin
		span_t exp_s;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				render_sample(channel, sample);
				req_taken = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (span_queue.size() == 0) begin
					$error("span request with none expected: column %0d", column);
					err_cnt++;
				end else begin
					exp_s = span_queue.pop_front();
					if (column !== exp_s.column) begin
						$error("column: expected %0d, got %0d", exp_s.column, column);
						err_cnt++;
					end
					if (row_top !== exp_s.row_top) begin
						$error("row_top: expected %0d, got %0d", exp_s.row_top, row_top);
						err_cnt++;
					end
					if (row_bottom !== exp_s.row_bottom) begin
						$error("row_bottom: expected %0d, got %0d",
							exp_s.row_bottom, row_bottom);
						err_cnt++;
					end
					if (pixel_color !== exp_s.pixel_color) begin
						$error("pixel_color: expected %h, got %h",
							exp_s.pixel_color, pixel_color);
						err_cnt++;
					end
					if (is_draw !== exp_s.is_draw) begin
						$error("is_draw: expected %0d, got %0d", exp_s.is_draw, is_draw);
						err_cnt++;
					end
					if (last !== exp_s.last) begin
						$error("last: expected %0d, got %0d", exp_s.last, last);
						err_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GAIN_CH0:   gain_reg[0]   = cfg_data[GAIN_W-1:0];
					CFG_GAIN_CH1:   gain_reg[1]   = cfg_data[GAIN_W-1:0];
					CFG_OFFSET_CH0: offset_reg[0] = cfg_data[OFFSET_W-1:0];
					CFG_OFFSET_CH1: offset_reg[1] = cfg_data[OFFSET_W-1:0];
					CFG_COLOR_CH0:  color_reg[0]  = cfg_data[COLOR_W-1:0];
					CFG_COLOR_CH1:  color_reg[1]  = cfg_data[COLOR_W-1:0];
					default: ;
				endcase
				cfg_written = 1'b1;
			end
		end
	end

	// Driver: hold a request until taken, then pull the next one unless idling.
	always @(negedge clk) begin
		sample_req_t r;
		if (arst_n) begin
			if (!in_valid || req_taken) begin
				if (sample_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
					r = sample_queue.pop_front();
					in_valid <= 1'b1;
					channel  <= r.ch;
					sample   <= r.smp;
				end else begin
					in_valid <= 1'b0;
				end
			end
			req_taken = 1'b0;
		end
	end

	// Receiver: stall the span channel at random.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic add_sample(input logic ch, input logic [SAMPLE_W-1:0] smp);
		sample_req_t r;
		r.ch  = ch;
		r.smp = smp;
		sample_queue.push_back(r);
	endtask

	task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_written = 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(negedge clk); while (!cfg_written);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every request is taken and every span is seen, then let the
	// pipeline settle. Check at the rising edge, where the driver's last update
	// of in_valid has already landed.
	task automatic wait_drained();
		do @(posedge clk);
		while (sample_queue.size() != 0 || in_valid || span_queue.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Gains: mostly a range that spreads samples over the screen, sometimes
	// the extremes or anything at all.
	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(9))
			0: return '0;
			1: return CFG_DATA_W'(20'hFFFFF);
			2, 3: return CFG_DATA_W'($urandom_range(20'hFFFFF));
			default: return CFG_DATA_W'($urandom_range(600, 4000));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_offset();
		case ($urandom_range(7))
			0: return '0;
			1: return CFG_DATA_W'(255);
			default: return CFG_DATA_W'($urandom_range(0, 120));
		endcase
	endfunction

	initial begin
		int phase_idle [4];
		int phase_stall[4];
		logic [SAMPLE_W-1:0] smp;

		gain_reg   = '{GAIN_W'(28494), GAIN_W'(28494)};
		offset_reg = '{OFFSET_W'(18), OFFSET_W'(114)};
		color_reg  = '{16'hFFE0, 16'h07FF};
		col_next   = '{0, 0};
		left_new_v = '{default: '0};
		left_old_v = '{default: '0};
		foreach (trace_mem[c, x]) trace_mem[c][x] = '0;

		phase_idle  = '{0, 88, 0, 22};
		phase_stall = '{0, 0, 88, 22};

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Reset registers: sample extremes on both channels, first frame erases zeros.
		add_sample(1'b0, 12'h000);
		add_sample(1'b0, 12'hFFF);
		add_sample(1'b0, 12'hAAA);
		add_sample(1'b0, 12'h555);
		add_sample(1'b0, 12'h001);
		add_sample(1'b1, 12'h000);
		add_sample(1'b1, 12'hFFF);
		add_sample(1'b1, 12'h800);
		wait_drained();

		// Register extremes: channel 0 flat at zero (both ends zero),
		// channel 1 pinned at the top value, colors all clear and all set.
		write_reg(CFG_GAIN_CH0, '0);
		write_reg(CFG_OFFSET_CH0, '0);
		write_reg(CFG_GAIN_CH1, CFG_DATA_W'(20'hFFFFF));
		write_reg(CFG_OFFSET_CH1, CFG_DATA_W'(255));
		write_reg(CFG_COLOR_CH0, '0);
		write_reg(CFG_COLOR_CH1, CFG_DATA_W'(16'hFFFF));
		add_sample(1'b0, 12'hFFF);
		add_sample(1'b0, 12'h000);
		add_sample(1'b0, 12'h7FF);
		add_sample(1'b1, 12'h000);
		add_sample(1'b1, 12'hFFF);
		add_sample(1'b1, 12'h7FF);
		add_sample(1'b1, 12'h001);
		wait_drained();

		// Random phases: fresh registers and a different idle and stall pattern each.
		// Channel 0 takes most samples so its column wraps into a second frame.
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_GAIN_CH0, pick_gain());
			write_reg(CFG_GAIN_CH1, pick_gain());
			write_reg(CFG_OFFSET_CH0, pick_offset());
			write_reg(CFG_OFFSET_CH1, pick_offset());
			write_reg(CFG_COLOR_CH0, CFG_DATA_W'($urandom_range(16'hFFFF)));
			write_reg(CFG_COLOR_CH1, CFG_DATA_W'($urandom_range(16'hFFFF)));
			idle_pct  = phase_idle[ph];
			stall_pct = phase_stall[ph];
			for (int i = 0; i < PHASE_SAMPLES; i++) begin
				case ($urandom_range(19))
					0: smp = '0;
					1: smp = '1;
					default: smp = SAMPLE_W'($urandom_range(12'hFFF));
				endcase
				add_sample($urandom_range(99) >= 80, smp);
			end
			wait_drained();
		end

		idle_pct  = 0;
		stall_pct = 0;
		repeat (10) @(negedge clk);
		if (err_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Stop a run that hangs on a handshake.
	initial begin
		#(TIMEOUT_CYCLES * 10);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
